// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL; i2cmbe_seq.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is asserted (active low).
`define ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_TICK     = 3'd0;
    localparam op_t OP_START    = 3'd1;
    localparam op_t OP_STOP     = 3'd2;
    localparam op_t OP_WRITE    = 3'd3;
    localparam op_t OP_GET_ACK  = 3'd4;
    localparam op_t OP_READ     = 3'd5;
    localparam op_t OP_SEND_ACK = 3'd6;

    localparam int TDATA_W = 16;
    localparam int TUSER_W = 3;
    localparam int WAIT_W  = 10;
    localparam int BITS_W  = 4;

    // Reset value of the delay unit length, in ticks.
    localparam logic [7:0] TPU_RESET = 8'd1;

    typedef struct packed {
        op_t        operation;
        logic [7:0] write_byte;
        logic       ack_level;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
        logic       command_rejected;
    } result_t;

endpackage

// ===== design/i2cmbe_seq.sv =====
`include "assert_macros.svh"

module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  item_t      item,
    input  logic [7:0] ticks_per_unit,
    output result_t    res
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_S1   = 4'd1,
        PH_S2   = 4'd2,
        PH_S3   = 4'd3,
        PH_S4   = 4'd4,
        PH_S5   = 4'd5,
        PH_S6   = 4'd6
    } phase_t;

    // Shift amounts for hold lengths of one, two and four units.
    localparam logic [1:0] U1 = 2'd0;
    localparam logic [1:0] U2 = 2'd1;
    localparam logic [1:0] U4 = 2'd2;

    phase_t              phase_reg, phase_next;
    op_t                 cmd_reg, cmd_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic [7:0]          shift_reg, shift_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                ack_reg, ack_next;
    logic [7:0]          rd_reg, rd_next;

    phase_t              ph_v;
    op_t                 cmd_v;
    logic [BITS_W-1:0]   bits_v;
    logic [BITS_W-1:0]   bits_inc;
    logic [7:0]          shift_v;
    logic [WAIT_W-1:0]   wait_dec;
    logic [7:0]          tick_eff;
    logic                is_cmd;
    logic                do_step;
    logic                done;
    logic                rejected;

    function automatic logic [WAIT_W-1:0] hold_ticks(input logic [7:0] t,
                                                     input logic [1:0] sh);
        hold_ticks = {{(WAIT_W-8){1'b0}}, t} << sh;
    endfunction

    assign tick_eff = (ticks_per_unit == 8'd0) ? 8'd1 : ticks_per_unit;
    assign is_cmd   = (item.operation >= OP_START) && (item.operation <= OP_SEND_ACK);
    assign wait_dec = (wait_reg != '0) ? wait_reg - 1'b1 : wait_reg;
    assign bits_inc = bits_v + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        bits_next  = bits_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rd_next    = rd_reg;
        ph_v       = phase_reg;
        cmd_v      = cmd_reg;
        bits_v     = bits_reg;
        shift_v    = shift_reg;
        do_step    = 1'b0;
        done       = 1'b0;
        rejected   = 1'b0;

        if (step_en) begin
            if (is_cmd) begin
                if (phase_reg != PH_IDLE) begin
                    rejected = 1'b1;
                end else begin
                    cmd_v  = item.operation;
                    bits_v = '0;
                    case (item.operation)
                        OP_WRITE:    shift_v = item.write_byte;
                        OP_READ:     shift_v = 8'h00;
                        OP_SEND_ACK: shift_v = {7'd0, item.ack_level};
                        default:     shift_v = shift_reg;
                    endcase
                    ph_v       = PH_S1;
                    cmd_next   = cmd_v;
                    bits_next  = bits_v;
                    shift_next = shift_v;
                    do_step    = 1'b1;
                end
            end else if (phase_reg != PH_IDLE) begin
                wait_next = wait_dec;
                do_step   = (wait_dec == '0);
            end
        end

        if (do_step) begin
            // Each step either schedules the next phase or ends the command.
            case (cmd_v)
                OP_START: begin
                    if (ph_v == PH_S1) begin
                        scl_next = 1'b1; sda_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U2); phase_next = PH_S2;
                    end else if (ph_v == PH_S2) begin
                        sda_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U2); phase_next = PH_S3;
                    end else begin
                        scl_next = 1'b0; done = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (ph_v == PH_S1) begin
                        scl_next = 1'b0; sda_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U2); phase_next = PH_S2;
                    end else if (ph_v == PH_S2) begin
                        scl_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U2); phase_next = PH_S3;
                    end else if (ph_v == PH_S3) begin
                        sda_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U2); phase_next = PH_S4;
                    end else begin
                        done = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (ph_v == PH_S1) begin
                        scl_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S2;
                    end else if (ph_v == PH_S2) begin
                        sda_next  = shift_v[3'd7 - bits_v[2:0]];
                        scl_next  = 1'b1;
                        bits_next = bits_inc;
                        wait_next = hold_ticks(tick_eff, U4);
                        phase_next = (bits_inc < BITS_W'(8)) ? PH_S1 : PH_S3;
                    end else if (ph_v == PH_S3) begin
                        scl_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S4;
                    end else begin
                        done = 1'b1;
                    end
                end
                OP_GET_ACK: begin
                    if (ph_v == PH_S1) begin
                        scl_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S2;
                    end else if (ph_v == PH_S2) begin
                        sda_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S3;
                    end else if (ph_v == PH_S3) begin
                        scl_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S4;
                    end else if (ph_v == PH_S4) begin
                        // A NACK ends the command at once with SCL left high.
                        if (!item.sda_sample) begin
                            ack_next = 1'b0; scl_next = 1'b0;
                            wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S5;
                        end else begin
                            ack_next = 1'b1; done = 1'b1;
                        end
                    end else begin
                        done = 1'b1;
                    end
                end
                OP_READ: begin
                    if (ph_v == PH_S1) begin
                        scl_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S2;
                    end else if (ph_v == PH_S2) begin
                        sda_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S3;
                    end else if (ph_v == PH_S3) begin
                        shift_next = {shift_v[6:0], 1'b0};
                        scl_next   = 1'b1;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S4;
                    end else if (ph_v == PH_S4) begin
                        shift_next = {shift_v[7:1], item.sda_sample};
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S5;
                    end else if (ph_v == PH_S5) begin
                        scl_next  = 1'b0;
                        bits_next = bits_inc;
                        wait_next = hold_ticks(tick_eff, U4);
                        phase_next = (bits_inc < BITS_W'(8)) ? PH_S3 : PH_S6;
                    end else begin
                        rd_next = shift_v; done = 1'b1;
                    end
                end
                OP_SEND_ACK: begin
                    if (ph_v == PH_S1) begin
                        scl_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S2;
                    end else if (ph_v == PH_S2) begin
                        sda_next = shift_v[0];
                        scl_next = 1'b1;
                        wait_next = hold_ticks(tick_eff, U2); phase_next = PH_S3;
                    end else if (ph_v == PH_S3) begin
                        scl_next = 1'b0;
                        wait_next = hold_ticks(tick_eff, U1); phase_next = PH_S4;
                    end else begin
                        done = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done) begin
                phase_next = PH_IDLE;
                wait_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= OP_TICK;
            bits_reg  <= '0;
            wait_reg  <= '0;
            shift_reg <= 8'h00;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b1;
            rd_reg    <= 8'h00;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bits_reg  <= bits_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rd_reg    <= rd_next;
        end
    end

    always_comb begin
        res.scl_level        = scl_next;
        res.sda_level        = sda_next;
        res.busy_res         = (phase_next != PH_IDLE);
        res.done_res         = done;
        res.read_data        = rd_next;
        res.ack_seen         = ack_next;
        res.command_rejected = rejected;
    end

    `ASSERT_SYNC(a_done_idle, aclk, aresetn, (step_en && done) |=> (phase_reg == PH_IDLE), "done without returning to idle")
    `ASSERT_SYNC(a_reject_hold, aclk, aresetn, (step_en && rejected) |=> ($stable(phase_reg) && $stable(wait_reg)), "rejected command changed the sequence")
    `ASSERT_SYNC(a_busy_wait, aclk, aresetn, (phase_reg != PH_IDLE) |-> (wait_reg != '0), "busy with no pending delay")
    `ASSERT_SYNC(a_no_step_hold, aclk, aresetn, !step_en |=> ($stable(phase_reg) && $stable(scl_reg) && $stable(sda_reg)), "state moved without an item")

endmodule

// ===== design/i2c_master_bit_engine_top.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tdata: write_byte, ack_level, sda_sample;
//                                           s_tuser: operation
// m_        out        m_tvalid/m_tready    m_tdata: pin levels, busy, done, read byte,
//                                           ack seen, rejected
// cfg_      in         cfg_valid/cfg_ready  cfg_data: ticks_per_unit
//
// Every item, tick or command, produces one result item after acceptance: it passes
// through the input register and then the result register.
// A new item is accepted every cycle while the result side keeps up.
// When m_tready is low the result register holds, the input register fills, then
// s_tready drops; no item is lost. Reset is synchronous and active low and
// releases both pins; the configuration register is always ready.
module i2c_master_bit_engine_top
    import i2cmbe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [7:0] write_byte, [8] ack_level, [9] sda_sample, [15:10] zero
    input  logic [TDATA_W-1:0] s_tdata,
    // [2:0] operation
    input  logic [TUSER_W-1:0] s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_seen, [13] command_rejected, [15:14] zero
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    logic               in_valid_reg, in_valid_next;
    item_t              in_item_reg, in_item_next;
    logic               out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    logic [7:0]         tpu_reg, tpu_next;
    logic               advance;
    logic               step_en;
    logic               s_accept;
    result_t            res;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign step_en   = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept) begin
            in_valid_next           = 1'b1;
            in_item_next.operation  = s_tuser[2:0];
            in_item_next.write_byte = s_tdata[7:0];
            in_item_next.ack_level  = s_tdata[8];
            in_item_next.sda_sample = s_tdata[9];
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, res.command_rejected, res.ack_seen, res.read_data,
                              res.done_res, res.busy_res, res.sda_level, res.scl_level};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        tpu_next = (cfg_valid && cfg_ready) ? cfg_data : tpu_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tpu_reg       <= TPU_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            tpu_reg       <= tpu_next;
        end
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    i2cmbe_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .item           (in_item_reg),
        .ticks_per_unit (tpu_reg),
        .res            (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== dv/i2c_bit_engine_checker.sv =====
`timescale 1ns / 100ps

module i2c_bit_engine_checker
    import i2cmbe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [TUSER_W-1:0] s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output int                 mismatches,
    output int                 results_due,
    output logic               seq_active
);

    localparam logic [3:0] STEP_IDLE = 4'd0;

    // Predicted engine state.
    logic [7:0]        unit_ticks;
    logic [3:0]        seq_step;
    op_t               seq_cmd;
    logic [BITS_W-1:0] bit_idx;
    logic [WAIT_W-1:0] tick_wait;
    logic [7:0]        shifter;
    logic              scl_drv;
    logic              sda_drv;
    logic              ack_bit;
    logic [7:0]        rd_byte;
    logic              finished;

    result_t expected_results[$];
    int      err_total = 0;

    assign mismatches = err_total;

    initial begin
        results_due = 0;
        seq_active  = 1'b0;
    end

    function automatic void clear_engine();
        unit_ticks = TPU_RESET;
        seq_step   = STEP_IDLE;
        seq_cmd    = OP_TICK;
        bit_idx    = '0;
        tick_wait  = '0;
        shifter    = 8'h00;
        scl_drv    = 1'b1;
        sda_drv    = 1'b1;
        ack_bit    = 1'b1;
        rd_byte    = 8'h00;
        finished   = 1'b0;
    endfunction

    // A register value of zero behaves as one tick per unit.
    function automatic void hold_for(int units, logic [3:0] nxt);
        int per_unit;
        per_unit  = (unit_ticks == 8'd0) ? 1 : int'(unit_ticks);
        tick_wait = WAIT_W'(units * per_unit);
        seq_step  = nxt;
    endfunction

    function automatic void end_seq();
        seq_step  = STEP_IDLE;
        tick_wait = '0;
        finished  = 1'b1;
    endfunction

    // Performs the pin step that belongs to the current step of the sequence.
    function automatic void advance(logic sda);
        case (seq_cmd)
            OP_START: begin
                if (seq_step == 4'd1) begin
                    scl_drv = 1'b1;
                    sda_drv = 1'b1;
                    hold_for(2, 4'd2);
                end else if (seq_step == 4'd2) begin
                    sda_drv = 1'b0;
                    hold_for(2, 4'd3);
                end else begin
                    scl_drv = 1'b0;
                    end_seq();
                end
            end
            OP_STOP: begin
                if (seq_step == 4'd1) begin
                    scl_drv = 1'b0;
                    sda_drv = 1'b0;
                    hold_for(2, 4'd2);
                end else if (seq_step == 4'd2) begin
                    scl_drv = 1'b1;
                    hold_for(2, 4'd3);
                end else if (seq_step == 4'd3) begin
                    sda_drv = 1'b1;
                    hold_for(2, 4'd4);
                end else begin
                    end_seq();
                end
            end
            OP_WRITE: begin
                if (seq_step == 4'd1) begin
                    scl_drv = 1'b0;
                    hold_for(1, 4'd2);
                end else if (seq_step == 4'd2) begin
                    sda_drv = shifter[3'd7 - bit_idx[2:0]];
                    scl_drv = 1'b1;
                    bit_idx = bit_idx + 1'b1;
                    hold_for(4, (bit_idx < 8) ? 4'd1 : 4'd3);
                end else if (seq_step == 4'd3) begin
                    scl_drv = 1'b0;
                    hold_for(1, 4'd4);
                end else begin
                    end_seq();
                end
            end
            OP_GET_ACK: begin
                if (seq_step == 4'd1) begin
                    scl_drv = 1'b0;
                    hold_for(1, 4'd2);
                end else if (seq_step == 4'd2) begin
                    sda_drv = 1'b1;
                    hold_for(1, 4'd3);
                end else if (seq_step == 4'd3) begin
                    scl_drv = 1'b1;
                    hold_for(1, 4'd4);
                end else if (seq_step == 4'd4) begin
                    // A NACK ends the command with SCL still released.
                    if (!sda) begin
                        ack_bit = 1'b0;
                        scl_drv = 1'b0;
                        hold_for(1, 4'd5);
                    end else begin
                        ack_bit = 1'b1;
                        end_seq();
                    end
                end else begin
                    end_seq();
                end
            end
            OP_READ: begin
                if (seq_step == 4'd1) begin
                    scl_drv = 1'b0;
                    hold_for(1, 4'd2);
                end else if (seq_step == 4'd2) begin
                    sda_drv = 1'b1;
                    hold_for(1, 4'd3);
                end else if (seq_step == 4'd3) begin
                    shifter = shifter << 1;
                    scl_drv = 1'b1;
                    hold_for(1, 4'd4);
                end else if (seq_step == 4'd4) begin
                    shifter[0] = sda;
                    hold_for(1, 4'd5);
                end else if (seq_step == 4'd5) begin
                    scl_drv = 1'b0;
                    bit_idx = bit_idx + 1'b1;
                    hold_for(4, (bit_idx < 8) ? 4'd3 : 4'd6);
                end else begin
                    rd_byte = shifter;
                    end_seq();
                end
            end
            OP_SEND_ACK: begin
                if (seq_step == 4'd1) begin
                    scl_drv = 1'b0;
                    hold_for(1, 4'd2);
                end else if (seq_step == 4'd2) begin
                    sda_drv = shifter[0];
                    scl_drv = 1'b1;
                    hold_for(2, 4'd3);
                end else if (seq_step == 4'd3) begin
                    scl_drv = 1'b0;
                    hold_for(1, 4'd4);
                end else begin
                    end_seq();
                end
            end
            default: end_seq();
        endcase
    endfunction

    function automatic result_t bus_step(item_t it);
        result_t r;
        logic    rejected;
        rejected = 1'b0;
        finished = 1'b0;
        if (it.operation >= OP_START && it.operation <= OP_SEND_ACK) begin
            if (seq_step != STEP_IDLE) begin
                rejected = 1'b1;
            end else begin
                seq_cmd = it.operation;
                bit_idx = '0;
                if (it.operation == OP_WRITE) begin
                    shifter = it.write_byte;
                end else if (it.operation == OP_READ) begin
                    shifter = 8'h00;
                end else if (it.operation == OP_SEND_ACK) begin
                    shifter = {7'b0, it.ack_level};
                end
                seq_step = 4'd1;
                advance(it.sda_sample);
            end
        end else if (seq_step != STEP_IDLE) begin
            // Ticks and the spare operation code only count down a running sequence.
            if (tick_wait > 0) tick_wait = tick_wait - 1'b1;
            if (tick_wait == 0) advance(it.sda_sample);
        end
        r.scl_level        = scl_drv;
        r.sda_level        = sda_drv;
        r.busy_res         = (seq_step != STEP_IDLE);
        r.done_res         = finished;
        r.read_data        = rd_byte;
        r.ack_seen         = ack_bit;
        r.command_rejected = rejected;
        return r;
    endfunction

    task automatic compare_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin
        item_t   it;
        result_t want;
        result_t got;
        if (!aresetn) begin
            clear_engine();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) unit_ticks = cfg_data;
            if (m_tvalid && m_tready) begin
                got.scl_level        = m_tdata[0];
                got.sda_level        = m_tdata[1];
                got.busy_res         = m_tdata[2];
                got.done_res         = m_tdata[3];
                got.read_data        = m_tdata[11:4];
                got.ack_seen         = m_tdata[12];
                got.command_rejected = m_tdata[13];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %0h",
                             $time, m_tdata);
                    err_total++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("scl_level", want.scl_level, got.scl_level);
                    compare_field("sda_level", want.sda_level, got.sda_level);
                    compare_field("busy_res", want.busy_res, got.busy_res);
                    compare_field("done_res", want.done_res, got.done_res);
                    compare_field("read_data", want.read_data, got.read_data);
                    compare_field("ack_seen", want.ack_seen, got.ack_seen);
                    compare_field("command_rejected", want.command_rejected,
                                  got.command_rejected);
                end
            end
            if (s_tvalid && s_tready) begin
                it.operation  = s_tuser[2:0];
                it.write_byte = s_tdata[7:0];
                it.ack_level  = s_tdata[8];
                it.sda_sample = s_tdata[9];
                expected_results.push_back(bus_step(it));
            end
        end
        results_due <= expected_results.size();
        seq_active  <= (seq_step != STEP_IDLE);
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import i2cmbe_pkg::*;

    localparam op_t OP_SPARE   = 3'd7;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  PHASE_ITEMS = 30;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [TUSER_W-1:0] s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data  = 8'd0;

    int   mismatches;
    int   results_due;
    logic seq_active;

    bit   gaps_on        = 1'b1;
    bit   stalls_on      = 1'b1;
    int   stall_requests = 0;
    int   stalls_served  = 0;
    int   holdoff_left   = 0;
    int   items_sent     = 0;
    int   cycles         = 0;
    int   tpu_now        = 1;

    i2c_master_bit_engine_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    i2c_bit_engine_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .results_due (results_due),
        .seq_active  (seq_active)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_tready <= 1'b0;
        end else if (stalls_served != stall_requests) begin
            stalls_served = stall_requests;
            holdoff_left  = 80;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(stalls_on && $urandom_range(99) < 14);
        end
    end

    function automatic logic pick_sda(int mode);
        if (mode == 0) return 1'b0;
        if (mode == 1) return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    // Returns at the edge where the item is accepted, with s_tvalid still high.
    task automatic push_item(op_t op, logic [7:0] wb, logic ackl, logic sda);
        if (gaps_on && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, sda, ackl, wb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Ticks, with an occasional command slipped in while the engine is busy.
    task automatic run_ticks(int n, int sda_mode, bit meddle);
        for (int i = 0; i < n; i++) begin
            if (meddle && $urandom_range(99) < 4)
                push_item(op_t'($urandom_range(OP_START, OP_SEND_ACK)), 8'($urandom),
                          1'($urandom), pick_sda(sda_mode));
            else
                push_item($urandom_range(99) < 10 ? OP_SPARE : OP_TICK, 8'($urandom),
                          1'($urandom), pick_sda(sda_mode));
        end
    endtask

    task automatic run_command(op_t op, logic [7:0] wb, logic ackl, int sda_mode, bit meddle);
        int units;
        int per;
        case (op)
            OP_START: units = 4;
            OP_STOP:  units = 6;
            OP_WRITE: units = 41;
            OP_READ:  units = 50;
            default:  units = 4;
        endcase
        per = (tpu_now == 0) ? 1 : tpu_now;
        push_item(op, wb, ackl, pick_sda(sda_mode));
        run_ticks(units * per + $urandom_range(0, 2), sda_mode, meddle);
    endtask

    // Waits until every result is in and the predicted engine is back at idle.
    task automatic settle();
        int per;
        s_tvalid <= 1'b0;
        forever begin
            do @(posedge aclk); while (results_due != 0);
            if (!seq_active) break;
            per = (tpu_now == 0) ? 1 : tpu_now;
            run_ticks(50 * per + 2, 2, 1'b0);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic write_unit_ticks(logic [7:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tpu_now = v;
    endtask

    task automatic random_sequence();
        int   r;
        op_t  cmd;
        r   = $urandom_range(99);
        cmd = op_t'($urandom_range(OP_START, OP_SEND_ACK));
        if (r < 8) begin
            push_item(op_t'($urandom_range(7)), 8'($urandom), 1'($urandom), 1'($urandom));
        end else if (r < 16) begin
            // Cut short, so the next command may find the engine still busy.
            push_item(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
            run_ticks($urandom_range(0, 6), 2, 1'b1);
        end else begin
            run_command(cmd, 8'($urandom), 1'($urandom), $urandom_range(0, 3), 1'b1);
        end
    endtask

    initial begin
        int target;
        int phase_tpu[6];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle ticks, every command, both acknowledge outcomes, a rejection.
        push_item(OP_TICK, 8'hFF, 1'b1, 1'b1);
        push_item(OP_SPARE, 8'h00, 1'b0, 1'b0);
        run_command(OP_START, 8'h00, 1'b0, 2, 1'b0);
        run_command(OP_WRITE, 8'hA5, 1'b0, 2, 1'b0);
        run_command(OP_GET_ACK, 8'h00, 1'b0, 0, 1'b0);
        run_command(OP_GET_ACK, 8'h00, 1'b0, 1, 1'b0);
        run_command(OP_READ, 8'h00, 1'b0, 2, 1'b0);
        run_command(OP_SEND_ACK, 8'hFF, 1'b0, 2, 1'b0);
        run_command(OP_SEND_ACK, 8'h00, 1'b1, 2, 1'b0);
        push_item(OP_STOP, 8'h00, 1'b0, 1'b0);
        push_item(OP_READ, 8'hFF, 1'b1, 1'b1);
        run_ticks(8, 2, 1'b0);

        // Zero behaves as one; the largest value runs one acknowledge read that sees a NACK.
        phase_tpu = '{1, 2, 0, 255, 3, 0};
        phase_tpu[5] = $urandom_range(1, 4);
        foreach (phase_tpu[p]) begin
            write_unit_ticks(8'(phase_tpu[p]));
            if (phase_tpu[p] == 255) begin
                push_item(OP_GET_ACK, 8'($urandom), 1'($urandom), 1'b1);
                run_ticks(3 * 255 + 2, 1, 1'b0);
                continue;
            end
            gaps_on   = (p != 1);
            stalls_on = (p != 1);
            if (p == 0 || p == 4) stall_requests++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_sequence();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
